// File: rtl/core/srse_pkg.sv
// Package: shared types and codes for the sorted range set engine.
package srse_pkg;

  localparam logic [2:0] KIND_ADD   = 3'd0;
  localparam logic [2:0] KIND_TRIM  = 3'd1;
  localparam logic [2:0] KIND_CONT  = 3'd2;
  localparam logic [2:0] KIND_CLEAR = 3'd3;
  localparam logic [2:0] KIND_ISTART = 3'd4;
  localparam logic [2:0] KIND_INEXT = 3'd5;
  localparam logic [2:0] KIND_CHECK = 3'd6;

  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_FULL     = 3'd1;
  localparam logic [2:0] ST_BADARG   = 3'd2;
  localparam logic [2:0] ST_NOTFOUND = 3'd3;
  localparam logic [2:0] ST_EXHAUST  = 3'd4;

  typedef struct packed {
    logic [2:0]  kind;
    logic [63:0] range_first;
    logic [63:0] range_count;
  } cmd_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [63:0] out_value;
    logic [63:0] total_count;
  } rsp_t;

  typedef struct packed {
    logic [63:0] start;
    logic [63:0] length;
  } entry_t;

endpackage

// File: rtl/core/srse_ram.sv
// Generic single-port-write, single-port-read RAM with registered read.
module srse_ram #(
  parameter int WIDTH = 128,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule

// File: rtl/core/sorted_range_set_engine_unit.sv
// Top level: sorted range set engine with a sequencer over a table RAM and a scratch RAM.
//
// One command transaction on cmd/cmd_valid/cmd_stall gives one response
// transaction on rsp/rsp_valid/rsp_stall. The table lives in RAM; valid
// entries are the lowest n slots, n held in a register, so reset clears the
// table at once by setting n to zero.
// Add, and range check on an empty table, run a read-and-merge sweep into
// a scratch RAM, then a copy back. Trim sweeps the table once, compacting
// in place. Contains and iterator start sweep n entries. Iterator next
// reads one entry per skipped slot, then sweeps for the total. Clear goes
// straight to the response.
// The running total is recomputed during the copy-back, trim and contains sweeps.
// One command is in work at a time; cmd_stall is high while busy or while a
// response waits. A stalled response holds its value until taken.
// After reset the table is empty and the iterator rewound.
module sorted_range_set_engine_unit #(
  parameter int ENTRIES = 16
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           cmd_valid,
  output logic           cmd_stall,
  input  srse_pkg::cmd_t cmd,
  output logic           rsp_valid,
  input  logic           rsp_stall,
  output srse_pkg::rsp_t rsp
);
  localparam int AW = $clog2(ENTRIES);
  localparam int CW = $clog2(ENTRIES + 2);
  localparam logic [63:0] MAXV = 64'hFFFF_FFFF_FFFF_FFFF;

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_MERGE = 4'd1;
  localparam logic [3:0] S_COPY  = 4'd2;
  localparam logic [3:0] S_TRIM  = 4'd3;
  localparam logic [3:0] S_CONT  = 4'd4;
  localparam logic [3:0] S_ITER  = 4'd5;
  localparam logic [3:0] S_RESP  = 4'd6;

  logic [3:0]  state;
  logic [CW-1:0] n, rd_i, wr_i, m;
  logic        rd_pend;
  logic [2:0]  kind;
  logic [63:0] first, len, wlast;
  logic        ins_done;
  logic        have_prev;
  logic [63:0] prev_s, prev_e;
  logic [63:0] total;
  logic [2:0]  status;
  logic [63:0] value;
  logic [CW-1:0] iter_entry;
  logic [63:0] iter_offset;
  logic        overflow;

  logic        t_we, s_we;
  logic [AW-1:0] t_wa, t_ra, s_wa, s_ra;
  srse_pkg::entry_t t_wd, t_rd, s_wd, s_rd;

  srse_ram #(.WIDTH(128), .DEPTH(ENTRIES)) u_table (
    .clk(clk), .we(t_we), .waddr(t_wa), .wdata(t_wd), .raddr(t_ra), .rdata(t_rd));
  srse_ram #(.WIDTH(128), .DEPTH(ENTRIES)) u_scratch (
    .clk(clk), .we(s_we), .waddr(s_wa), .wdata(s_wd), .raddr(s_ra), .rdata(s_rd));

  function automatic logic [63:0] sat_add(input logic [63:0] a, input logic [63:0] b);
    logic [64:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[64] ? MAXV : s[63:0];
  endfunction

  function automatic logic [63:0] end_of(input logic [63:0] s, input logic [63:0] l);
    return s + (l - 64'd1);
  endfunction

  assign cmd_stall = (state != S_IDLE) || rsp_valid;

  // merge candidate for this cycle
  logic        mc_valid, mc_is_new;
  logic [63:0] mc_s, mc_l, mc_e;
  logic        rd_fire;
  logic [63:0] tr_s, tr_e;
  logic        tr_keep;

  always_comb begin
    mc_valid = 1'b0;
    mc_is_new = 1'b0;
    mc_s = t_rd.start;
    mc_l = t_rd.length;
    if (state == S_MERGE) begin
      if (rd_pend) begin
        if (!ins_done && (first < t_rd.start ||
            (first == t_rd.start && len < t_rd.length))) begin
          mc_is_new = 1'b1;
          mc_s = first;
          mc_l = len;
        end
        mc_valid = 1'b1;
      end else if (!ins_done && rd_i >= n) begin
        mc_is_new = 1'b1;
        mc_s = first;
        mc_l = len;
        mc_valid = 1'b1;
      end
    end
    mc_e = end_of(mc_s, mc_l);
    tr_s = t_rd.start;
    tr_e = end_of(t_rd.start, t_rd.length);
    tr_keep = 1'b1;
    if (t_rd.start != 64'd0) begin
      if (tr_s < first) tr_s = first;
      if (tr_e > wlast) tr_e = wlast;
      tr_keep = tr_s <= tr_e;
    end
  end

  // reads: in merge, a new candidate consumes no entry, so reissue same index
  assign rd_fire = (state == S_MERGE) ? (rd_i < n && !(rd_pend && mc_is_new)) :
                   (state == S_TRIM || state == S_CONT) ? (rd_i < n) :
                   1'b0;
  assign t_ra = (state == S_ITER) ? iter_entry[AW-1:0] :
                (state == S_MERGE && rd_pend && mc_is_new) ? rd_i[AW-1:0] - AW'(1) :
                rd_i[AW-1:0];
  assign s_ra = rd_i[AW-1:0];

  logic        merges;
  assign merges = mc_valid && mc_s != 64'd0 && have_prev && prev_e >= mc_s;

  always_comb begin
    s_we = 1'b0;
    s_wa = m[AW-1:0];
    s_wd = '{start: mc_s, length: mc_l};
    t_we = 1'b0;
    t_wa = wr_i[AW-1:0];
    t_wd = s_rd;
    if (state == S_MERGE && mc_valid) begin
      if (merges) begin
        s_we = 1'b1;
        s_wa = m[AW-1:0] - AW'(1);
        s_wd = '{start: prev_s,
                 length: ((mc_e > prev_e) ? mc_e : prev_e) - prev_s + 64'd1};
      end else begin
        s_we = (m < CW'(ENTRIES));
      end
    end
    if (state == S_COPY && rd_pend) t_we = 1'b1;
    if (state == S_TRIM && rd_pend && tr_keep) begin
      t_we = 1'b1;
      t_wa = m[AW-1:0];
      t_wd = '{start: tr_s, length: tr_e - tr_s + 64'd1};
    end
  end

  logic [63:0] cnt_m1;
  assign cnt_m1 = cmd.range_count - 64'd1;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      n <= '0;
      rsp_valid <= 1'b0;
      iter_entry <= '0;
      iter_offset <= '0;
      rd_pend <= 1'b0;
    end else begin
      if (rsp_valid && !rsp_stall) rsp_valid <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (cmd_valid && !cmd_stall) begin
            kind <= cmd.kind;
            first <= cmd.range_first;
            rd_i <= '0;
            wr_i <= '0;
            m <= '0;
            rd_pend <= 1'b0;
            ins_done <= 1'b0;
            have_prev <= 1'b0;
            overflow <= 1'b0;
            total <= '0;
            status <= srse_pkg::ST_OK;
            value <= '0;
            if (cmd.range_count == 64'd0) begin
              len <= 64'd1;
            end else if (cnt_m1 > MAXV - cmd.range_first) begin
              len <= MAXV - cmd.range_first + 64'd1;
            end else begin
              len <= cmd.range_count;
            end
            wlast <= (cnt_m1 > MAXV - cmd.range_first) ? MAXV :
                     cmd.range_first + cnt_m1;
            case (cmd.kind)
              srse_pkg::KIND_ADD: state <= S_MERGE;
              srse_pkg::KIND_CHECK: state <= (n == '0) ? S_MERGE :
                                     (cmd.range_count == 64'd0) ? S_CONT : S_TRIM;
              srse_pkg::KIND_TRIM: state <= (cmd.range_count == 64'd0) ? S_CONT : S_TRIM;
              srse_pkg::KIND_CONT: state <= S_CONT;
              srse_pkg::KIND_CLEAR: begin
                n <= '0;
                state <= S_RESP;
              end
              srse_pkg::KIND_ISTART: begin
                iter_entry <= '0;
                iter_offset <= '0;
                state <= S_CONT;
              end
              srse_pkg::KIND_INEXT: state <= S_ITER;
              default: state <= S_CONT;
            endcase
          end
        end
        S_MERGE: begin
          rd_pend <= rd_fire || (rd_pend && mc_is_new);
          if (rd_fire) rd_i <= rd_i + CW'(1);
          if (mc_valid) begin
            if (mc_is_new) ins_done <= 1'b1;
            if (merges) begin
              if (mc_e > prev_e) prev_e <= mc_e;
            end else begin
              if (m >= CW'(ENTRIES)) overflow <= 1'b1;
              else m <= m + CW'(1);
              if (mc_s != 64'd0) begin
                have_prev <= 1'b1;
                prev_s <= mc_s;
                prev_e <= mc_e;
              end
            end
          end
          if (!rd_fire && !(mc_valid && !mc_is_new && !ins_done) &&
              ins_done | (mc_valid && mc_is_new)) begin
            if (!(rd_pend && mc_is_new && rd_i < n) && !(rd_pend && mc_is_new)) begin
              state <= S_COPY;
              rd_i <= '0;
              rd_pend <= 1'b0;
            end
          end
        end
        S_COPY: begin
          if (overflow) begin
            status <= srse_pkg::ST_FULL;
            rd_i <= '0;
            state <= S_CONT;
          end else begin
            rd_pend <= rd_i < m;
            if (rd_i < m) rd_i <= rd_i + CW'(1);
            if (rd_pend) begin
              wr_i <= wr_i + CW'(1);
              total <= sat_add(total, s_rd.length);
            end
            if (!(rd_i < m) && !rd_pend) begin
              n <= m;
              state <= S_RESP;
            end
          end
        end
        S_TRIM: begin
          rd_pend <= rd_fire;
          if (rd_fire) rd_i <= rd_i + CW'(1);
          if (rd_pend && tr_keep) begin
            m <= m + CW'(1);
            total <= sat_add(total, tr_e - tr_s + 64'd1);
          end
          if (!rd_fire && !rd_pend) begin
            n <= m;
            state <= S_RESP;
          end
        end
        S_CONT: begin
          // contains probe and total recompute share this sweep
          rd_pend <= rd_fire;
          if (rd_fire) rd_i <= rd_i + CW'(1);
          if (rd_pend) begin
            total <= sat_add(total, t_rd.length);
            if (kind == srse_pkg::KIND_CONT && t_rd.start <= first &&
                first <= end_of(t_rd.start, t_rd.length))
              m <= m + CW'(1);
          end
          if (!rd_fire && !rd_pend) begin
            state <= S_RESP;
            case (kind)
              srse_pkg::KIND_CONT: if (m == '0) status <= srse_pkg::ST_NOTFOUND;
              srse_pkg::KIND_ISTART: if (n == '0) status <= srse_pkg::ST_BADARG;
              srse_pkg::KIND_TRIM, srse_pkg::KIND_CHECK: begin
                if (status != srse_pkg::ST_FULL) status <= srse_pkg::ST_BADARG;
              end
              srse_pkg::KIND_ADD: ;
              srse_pkg::KIND_CLEAR: ;
              default: status <= srse_pkg::ST_BADARG;
            endcase
          end
        end
        S_ITER: begin
          if (iter_entry >= n) begin
            status <= srse_pkg::ST_EXHAUST;
            rd_i <= '0;
            rd_pend <= 1'b0;
            kind <= srse_pkg::KIND_CLEAR;
            state <= S_CONT;
          end else if (!rd_pend) begin
            rd_pend <= 1'b1;
          end else begin
            rd_pend <= 1'b0;
            if (iter_offset >= t_rd.length) begin
              iter_entry <= iter_entry + CW'(1);
              iter_offset <= '0;
            end else begin
              value <= t_rd.start + iter_offset;
              if (iter_offset + 64'd1 >= t_rd.length) begin
                iter_entry <= iter_entry + CW'(1);
                iter_offset <= '0;
              end else begin
                iter_offset <= iter_offset + 64'd1;
              end
              rd_i <= '0;
              kind <= srse_pkg::KIND_CLEAR;
              state <= S_CONT;
            end
          end
        end
        S_RESP: begin
          rsp_valid <= 1'b1;
          rsp <= '{status: status, out_value: value, total_count: total};
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule

// File: tb/tb_sorted_range_set_engine_unit.sv
// Testbench: random and directed command checking of the sorted range set engine.
`timescale 1ns / 100ps

module tb_sorted_range_set_engine_unit;

  localparam int NSLOT = 16;
  localparam longint unsigned MAXV = 64'hFFFF_FFFF_FFFF_FFFF;
  localparam int LIMIT = 2000000;

  logic clk;
  logic rst;
  logic cmd_valid;
  logic cmd_stall;
  srse_pkg::cmd_t cmd;
  logic rsp_valid;
  logic rsp_stall;
  srse_pkg::rsp_t rsp;

  sorted_range_set_engine_unit #(.ENTRIES(NSLOT)) uut (
    .clk(clk), .rst(rst), .cmd_valid(cmd_valid), .cmd_stall(cmd_stall), .cmd(cmd),
    .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp(rsp)
  );

  logic [63:0] tab_start [NSLOT];
  logic [63:0] tab_len [NSLOT];
  int          tab_n;
  int          it_entry;
  logic [63:0] it_offset;

  srse_pkg::rsp_t pending_rsp [$];
  int   mismatches;
  int   cycle_count;
  int   hold_off;
  bit   rsp_random;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic logic [63:0] range_last(logic [63:0] s, logic [63:0] l);
    return s + (l - 64'd1);
  endfunction

  function automatic logic [63:0] table_total();
    logic [63:0] t;
    t = 64'd0;
    for (int i = 0; i < tab_n; i++) begin
      if (tab_len[i] > MAXV - t) t = MAXV;
      else t = t + tab_len[i];
    end
    return t;
  endfunction

  function automatic logic [2:0] merge_add(logic [63:0] first, logic [63:0] count);
    logic [63:0] ts [NSLOT+1];
    logic [63:0] tl [NSLOT+1];
    logic [63:0] os [NSLOT+1];
    logic [63:0] ol [NSLOT+1];
    logic [63:0] last, len, e;
    int pos, m, prev;
    pos = 0;
    m = 0;
    prev = -1;
    if (count == 0) last = first;
    else if (count - 1 > MAXV - first) last = MAXV;
    else last = first + (count - 1);
    len = last - first + 1;
    while (pos < tab_n && (tab_start[pos] < first ||
           (tab_start[pos] == first && tab_len[pos] <= len))) pos++;
    for (int i = 0; i < pos; i++) begin
      ts[i] = tab_start[i]; tl[i] = tab_len[i];
    end
    ts[pos] = first; tl[pos] = len;
    for (int i = pos; i < tab_n; i++) begin
      ts[i+1] = tab_start[i]; tl[i+1] = tab_len[i];
    end
    for (int i = 0; i <= tab_n; i++) begin
      if (ts[i] != 0 && prev >= 0 && range_last(os[prev], ol[prev]) >= ts[i]) begin
        e = range_last(ts[i], tl[i]);
        if (e > range_last(os[prev], ol[prev])) ol[prev] = e - os[prev] + 1;
      end else begin
        os[m] = ts[i]; ol[m] = tl[i];
        if (ts[i] != 0) prev = m;
        m++;
      end
    end
    if (m > NSLOT) return srse_pkg::ST_FULL;
    for (int i = 0; i < NSLOT; i++) begin
      tab_start[i] = i < m ? os[i] : 64'd0;
      tab_len[i] = i < m ? ol[i] : 64'd0;
    end
    tab_n = m;
    return srse_pkg::ST_OK;
  endfunction

  function automatic logic [2:0] window_trim(logic [63:0] first, logic [63:0] count);
    logic [63:0] wlast, s, e;
    int m;
    m = 0;
    if (count == 0) return srse_pkg::ST_BADARG;
    wlast = (count - 1 > MAXV - first) ? MAXV : first + (count - 1);
    for (int i = 0; i < tab_n; i++) begin
      s = tab_start[i];
      e = range_last(s, tab_len[i]);
      if (s != 0) begin
        if (s < first) s = first;
        if (e > wlast) e = wlast;
      end
      if (s == 0 || s <= e) begin
        tab_start[m] = s;
        tab_len[m] = e - s + 1;
        m++;
      end
    end
    for (int i = m; i < NSLOT; i++) begin
      tab_start[i] = 64'd0; tab_len[i] = 64'd0;
    end
    tab_n = m;
    return srse_pkg::ST_OK;
  endfunction

  function automatic srse_pkg::rsp_t predict_range_set(srse_pkg::cmd_t c);
    srse_pkg::rsp_t r;
    r.status = srse_pkg::ST_OK;
    r.out_value = 64'd0;
    case (c.kind)
      srse_pkg::KIND_ADD: r.status = merge_add(c.range_first, c.range_count);
      srse_pkg::KIND_TRIM: r.status = window_trim(c.range_first, c.range_count);
      srse_pkg::KIND_CONT: begin
        r.status = srse_pkg::ST_NOTFOUND;
        for (int i = 0; i < tab_n; i++)
          if (tab_start[i] <= c.range_first &&
              c.range_first <= range_last(tab_start[i], tab_len[i]))
            r.status = srse_pkg::ST_OK;
      end
      srse_pkg::KIND_CLEAR: begin
        for (int i = 0; i < NSLOT; i++) begin
          tab_start[i] = 64'd0; tab_len[i] = 64'd0;
        end
        tab_n = 0;
      end
      srse_pkg::KIND_ISTART: begin
        it_entry = 0;
        it_offset = 64'd0;
        if (tab_n == 0) r.status = srse_pkg::ST_BADARG;
      end
      srse_pkg::KIND_INEXT: begin
        while (it_entry < tab_n && it_offset >= tab_len[it_entry]) begin
          it_entry++;
          it_offset = 64'd0;
        end
        if (it_entry >= tab_n) r.status = srse_pkg::ST_EXHAUST;
        else begin
          r.out_value = tab_start[it_entry] + it_offset;
          it_offset++;
          if (it_offset >= tab_len[it_entry]) begin
            it_entry++;
            it_offset = 64'd0;
          end
        end
      end
      srse_pkg::KIND_CHECK: begin
        if (tab_n == 0) r.status = merge_add(c.range_first, c.range_count);
        else r.status = window_trim(c.range_first, c.range_count);
      end
      default: r.status = srse_pkg::ST_BADARG;
    endcase
    r.total_count = table_total();
    return r;
  endfunction

  task automatic send_cmd(logic [2:0] kind, logic [63:0] first, logic [63:0] count);
    srse_pkg::cmd_t c;
    int gap;
    gap = $urandom_range(0, 9);
    if (gap > 0) begin
      cmd_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    c.kind = kind;
    c.range_first = first;
    c.range_count = count;
    cmd <= c;
    cmd_valid <= 1'b1;
    @(posedge clk);
    while (cmd_stall) @(posedge clk);
    pending_rsp.push_back(predict_range_set(c));
  endtask

  always @(posedge clk) begin
    srse_pkg::rsp_t exp_r;
    if (!rst && rsp_valid && !rsp_stall) begin
      if (pending_rsp.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected response %h", rsp);
      end else begin
        exp_r = pending_rsp.pop_front();
        if (rsp.status !== exp_r.status || rsp.out_value !== exp_r.out_value ||
            rsp.total_count !== exp_r.total_count) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: exp st=%0d val=%h tot=%h got st=%0d val=%h tot=%h",
                     exp_r.status, exp_r.out_value, exp_r.total_count,
                     rsp.status, rsp.out_value, rsp.total_count);
        end
      end
    end
  end

  // Receiver stall: random wait per transaction, or a long hold-off.
  initial begin
    int w;
    rsp_stall = 1'b1;
    @(negedge rst);
    forever begin
      if (hold_off > 0) begin
        rsp_stall <= 1'b1;
        repeat (hold_off) @(posedge clk);
        hold_off = 0;
      end
      w = rsp_random ? $urandom_range(0, 9) : 0;
      if (w > 0) begin
        rsp_stall <= 1'b1;
        repeat (w) @(posedge clk);
      end
      rsp_stall <= 1'b0;
      @(posedge clk);
      while (!rsp_valid && hold_off == 0) @(posedge clk);
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  function automatic logic [63:0] rand64();
    return {$urandom(), $urandom()};
  endfunction

  function automatic logic [63:0] small_val();
    return 64'($urandom_range(0, 200));
  endfunction

  task automatic test_directed();
    send_cmd(srse_pkg::KIND_ISTART, 0, 0);
    send_cmd(srse_pkg::KIND_INEXT, 0, 0);
    send_cmd(srse_pkg::KIND_ADD, 10, 0);
    send_cmd(srse_pkg::KIND_ADD, 20, 5);
    send_cmd(srse_pkg::KIND_ADD, 25, 3);
    send_cmd(srse_pkg::KIND_ADD, 22, 10);
    send_cmd(srse_pkg::KIND_ADD, 0, 4);
    send_cmd(srse_pkg::KIND_ADD, MAXV - 2, 64'd100);
    send_cmd(srse_pkg::KIND_ADD, 64'd5, MAXV);
    send_cmd(srse_pkg::KIND_CONT, 11, 0);
    send_cmd(srse_pkg::KIND_CONT, 0, 0);
    send_cmd(srse_pkg::KIND_CONT, MAXV, 0);
    send_cmd(srse_pkg::KIND_TRIM, 3, 0);
    send_cmd(srse_pkg::KIND_TRIM, 8, 20);
    send_cmd(srse_pkg::KIND_ISTART, 0, 0);
    repeat (5) send_cmd(srse_pkg::KIND_INEXT, 0, 0);
    send_cmd(srse_pkg::KIND_CHECK, 9, 3);
    send_cmd(srse_pkg::KIND_CLEAR, 0, 0);
    send_cmd(srse_pkg::KIND_CHECK, MAXV, MAXV);
    send_cmd(3'd7, MAXV, MAXV);
    send_cmd(srse_pkg::KIND_CLEAR, 0, 0);
  endtask

  task automatic test_table_full();
    for (int i = 0; i < 18; i++) send_cmd(srse_pkg::KIND_ADD, 64'(3 * i + 1), 1);
    send_cmd(srse_pkg::KIND_ISTART, 0, 0);
    send_cmd(srse_pkg::KIND_TRIM, 4, 30);
    send_cmd(srse_pkg::KIND_INEXT, 0, 0);
    send_cmd(srse_pkg::KIND_INEXT, 0, 0);
  endtask

  task automatic test_random();
    logic [2:0] k;
    logic [63:0] f, c;
    rsp_random = 1'b1;
    for (int i = 0; i < 333; i++) begin
      k = 3'($urandom_range(0, 7));
      if ($urandom_range(0, 9) < 4) k = srse_pkg::KIND_ADD;
      else if ($urandom_range(0, 3) == 0) k = srse_pkg::KIND_INEXT;
      if ($urandom_range(0, 7) == 0) begin
        f = rand64(); c = rand64();
      end else begin
        f = small_val(); c = 64'($urandom_range(0, 12));
        if (k == srse_pkg::KIND_TRIM || k == srse_pkg::KIND_CHECK)
          c = 64'($urandom_range(0, 150));
      end
      if ($urandom_range(0, 40) == 0) k = srse_pkg::KIND_CLEAR;
      send_cmd(k, f, c);
    end
  endtask

  task automatic test_backpressure();
    hold_off = 300;
    for (int i = 0; i < 20; i++)
      send_cmd(i % 3 == 0 ? srse_pkg::KIND_CONT : srse_pkg::KIND_ADD, small_val(), 3);
  endtask

  initial begin
    rst = 1'b1;
    cmd_valid = 1'b0;
    cmd = '0;
    mismatches = 0;
    cycle_count = 0;
    hold_off = 0;
    rsp_random = 1'b1;
    tab_n = 0;
    it_entry = 0;
    it_offset = 64'd0;
    for (int i = 0; i < NSLOT; i++) begin
      tab_start[i] = 64'd0; tab_len[i] = 64'd0;
    end
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_table_full();
    test_backpressure();
    test_random();
    cmd_valid <= 1'b0;
    while (pending_rsp.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    if (mismatches == 0 && pending_rsp.size() == 0) $display("status: pass");
    else $display("status: fail");
    $finish;
  end

endmodule
